@@ hw/rtl/dtmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared constants, defaults and types for the DTMF dual-tone generator.
// ----------------------------------------------------------------------------
package dtmf_pkg;

  // default build parameters
  localparam int DEF_SAMPLE_RATE = 44100;
  localparam int DEF_PHASE_BITS  = 32;
  localparam int DEF_SINE_DEPTH  = 1024;

  // field and register widths
  localparam int DIGIT_W    = 4;
  localparam int AMP_W      = 15;
  localparam int COUNT_W    = 24;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_SAMPLES = 1'd1;

  // register reset values
  localparam logic [AMP_W-1:0]   AMP_RESET  = 15'd16384;
  localparam logic [COUNT_W-1:0] TONE_RESET = 24'd441000;

  // highest valid key
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // keypad frequencies in hz
  localparam int ROW_HZ_0 = 697;
  localparam int ROW_HZ_1 = 770;
  localparam int ROW_HZ_2 = 852;
  localparam int ROW_HZ_3 = 941;
  localparam int COL_HZ_0 = 1209;
  localparam int COL_HZ_1 = 1336;
  localparam int COL_HZ_2 = 1477;

  // per-sample control travelling down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic bad;
  } dtmf_ctrl_t;

endpackage

@@ hw/rtl/dtmf_ram.sv @@
// ----------------------------------------------------------------------------
// dtmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtmf_ram #(
  parameter int Width = 8,
  parameter int Depth = 1,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, returns old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dtmf_sine_rom.sv @@
// ----------------------------------------------------------------------------
// dtmf_sine_rom
// Full-wave Q2.14 sine table built at elaboration, registered read.
// ----------------------------------------------------------------------------
module dtmf_sine_rom #(
  parameter int Depth = 1024,
  localparam int IdxW = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic [IdxW-1:0]     addr_i,
  output logic signed [15:0]  data_o
);

  // pi in Q2.30 and the taylor series divisors (2n)(2n+1)
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = PI_Q30 / 64'd2;
  localparam logic [63:0] HALF_DEPTH = 64'(Depth / 2);
  localparam logic [63:0] DEPTH64 = 64'(Depth);
  localparam logic [63:0] TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210};

  // one table entry: quadrant fold, series to x^15, round half up to Q2.14
  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    longint      sum;
    logic        neg;
    int          n;
    theta = (64'd2 * PI_Q30 * 64'(k) + HALF_DEPTH) / DEPTH64;
    neg   = 1'b0;
    if (theta >= PI_Q30) begin
      theta = theta - PI_Q30;
      neg   = 1'b1;
    end
    if (theta > HALF_PI_Q30) begin
      theta = PI_Q30 - theta;
    end
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = longint'(theta);
    for (n = 0; n < 7; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n[0] == 1'b0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = ((64'(sum) * 64'd16384) + (64'd1 << 29)) >> 30;
    return neg ? 16'(-v) : 16'(v);
  endfunction

  logic signed [15:0] rom_table [Depth];
  logic signed [15:0] data_q;

  // constant table contents
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    assign rom_table[k] = sine_entry(k);
  end

  // registered lookup
  always_ff @(posedge clk_i) begin
    data_q <= rom_table[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ hw/rtl/dtmf_phase.sv @@
// ----------------------------------------------------------------------------
// dtmf_phase
// Phase and sample-count state held in a one-entry RAM: read on each
// transfer, updated and written back, with write-to-read forwarding.
// ----------------------------------------------------------------------------
module dtmf_phase #(
  parameter int SampleRate = 44100,
  parameter int PhaseBits  = 32,
  parameter int SineDepth  = 1024,
  localparam int IdxW = $clog2(SineDepth)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [dtmf_pkg::DIGIT_W-1:0]      digit_i,
  input  logic                              start_i,
  input  logic [dtmf_pkg::COUNT_W-1:0]      tone_samples_i,
  output logic [IdxW-1:0]                   row_idx_o,
  output logic [IdxW-1:0]                   col_idx_o,
  output dtmf_pkg::dtmf_ctrl_t              ctrl_o
);
  import dtmf_pkg::*;

  localparam int StateW = 2 * PhaseBits + COUNT_W;
  localparam int ProdW  = PhaseBits + IdxW;
  localparam logic [63:0] RATE64    = 64'(SampleRate);
  localparam logic [63:0] HALF_RATE = 64'(SampleRate / 2);

  // phase increments: round(f * 2^PhaseBits / SampleRate)
  localparam logic [PhaseBits-1:0] ROW_STEP_0 =
    PhaseBits'(((64'(ROW_HZ_0) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] ROW_STEP_1 =
    PhaseBits'(((64'(ROW_HZ_1) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] ROW_STEP_2 =
    PhaseBits'(((64'(ROW_HZ_2) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] ROW_STEP_3 =
    PhaseBits'(((64'(ROW_HZ_3) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] COL_STEP_0 =
    PhaseBits'(((64'(COL_HZ_0) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] COL_STEP_1 =
    PhaseBits'(((64'(COL_HZ_1) << PhaseBits) + HALF_RATE) / RATE64);
  localparam logic [PhaseBits-1:0] COL_STEP_2 =
    PhaseBits'(((64'(COL_HZ_2) << PhaseBits) + HALF_RATE) / RATE64);

  // first stage registers
  logic                 s1_valid_q;
  logic [DIGIT_W-1:0]   s1_digit_q;
  logic                 s1_start_q;

  // forwarding and initial-contents tracking
  logic                 fwd_valid_q;
  logic [StateW-1:0]    fwd_q;
  logic                 wrote_q;

  logic [StateW-1:0]    rdata;
  logic [StateW-1:0]    cur_state;
  logic [StateW-1:0]    next_state;
  logic [PhaseBits-1:0] row_cur;
  logic [PhaseBits-1:0] col_cur;
  logic [COUNT_W-1:0]   cnt_cur;
  logic [PhaseBits-1:0] row_nxt;
  logic [PhaseBits-1:0] col_nxt;
  logic [COUNT_W-1:0]   cnt_nxt;
  logic [COUNT_W-1:0]   cnt_inc;
  logic [PhaseBits-1:0] row_step;
  logic [PhaseBits-1:0] col_step;
  logic [ProdW-1:0]     row_prod;
  logic [ProdW-1:0]     col_prod;
  logic                 bad;
  logic                 last;
  dtmf_ctrl_t           ctrl_q;

  // state memory, single entry
  dtmf_ram #(
    .Width (StateW),
    .Depth (1)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (1'b0),
    .wdata_i (next_state),
    .re_i    (accept_i),
    .raddr_i (1'b0),
    .rdata_o (rdata)
  );

  // capture the item while the state read is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_digit_q <= digit_i;
      s1_start_q <= start_i;
    end
  end

  // pick forwarded, stored or reset state
  always_comb begin
    if (fwd_valid_q) begin
      cur_state = fwd_q;
    end else if (wrote_q) begin
      cur_state = rdata;
    end else begin
      cur_state = '0;
    end
  end

  // start request clears phases and count before use
  always_comb begin
    row_cur = cur_state[StateW-1 -: PhaseBits];
    col_cur = cur_state[COUNT_W +: PhaseBits];
    cnt_cur = cur_state[COUNT_W-1:0];
    if (s1_start_q) begin
      row_cur = '0;
      col_cur = '0;
      cnt_cur = '0;
    end
  end

  // keypad to frequency pair
  always_comb begin
    case (s1_digit_q)
      4'd0:    begin row_step = ROW_STEP_3; col_step = COL_STEP_1; end
      4'd1:    begin row_step = ROW_STEP_0; col_step = COL_STEP_0; end
      4'd2:    begin row_step = ROW_STEP_0; col_step = COL_STEP_1; end
      4'd3:    begin row_step = ROW_STEP_0; col_step = COL_STEP_2; end
      4'd4:    begin row_step = ROW_STEP_1; col_step = COL_STEP_0; end
      4'd5:    begin row_step = ROW_STEP_1; col_step = COL_STEP_1; end
      4'd6:    begin row_step = ROW_STEP_1; col_step = COL_STEP_2; end
      4'd7:    begin row_step = ROW_STEP_2; col_step = COL_STEP_0; end
      4'd8:    begin row_step = ROW_STEP_2; col_step = COL_STEP_1; end
      4'd9:    begin row_step = ROW_STEP_2; col_step = COL_STEP_2; end
      default: begin row_step = '0;         col_step = '0;         end
    endcase
  end

  // table index from the phase before it advances
  assign row_prod  = ProdW'(row_cur) * ProdW'(SineDepth);
  assign col_prod  = ProdW'(col_cur) * ProdW'(SineDepth);
  assign row_idx_o = row_prod[ProdW-1:PhaseBits];
  assign col_idx_o = col_prod[ProdW-1:PhaseBits];

  // phase advance, burst count and burst end
  assign bad     = s1_digit_q > DIGIT_MAX;
  assign cnt_inc = cnt_cur + COUNT_W'(1);
  assign last    = cnt_inc == tone_samples_i;

  always_comb begin
    row_nxt = bad ? row_cur : row_cur + row_step;
    col_nxt = bad ? col_cur : col_cur + col_step;
    cnt_nxt = cnt_inc;
    if (last) begin
      row_nxt = '0;
      col_nxt = '0;
      cnt_nxt = '0;
    end
  end

  assign next_state = {row_nxt, col_nxt, cnt_nxt};

  // a write at this edge is invisible to a read issued at this edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      wrote_q     <= 1'b0;
    end else begin
      fwd_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        wrote_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_q <= next_state;
    end
  end

  // control aligned with the table outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q.valid <= s1_valid_q;
      ctrl_q.last  <= last;
      ctrl_q.bad   <= bad;
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

@@ hw/rtl/dtmf_mix.sv @@
// ----------------------------------------------------------------------------
// dtmf_mix
// Sums the two sines, scales by the amplitude, rounds and saturates.
// ----------------------------------------------------------------------------
module dtmf_mix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dtmf_pkg::dtmf_ctrl_t                 ctrl_i,
  input  logic signed [15:0]                   row_sin_i,
  input  logic signed [15:0]                   col_sin_i,
  input  logic [dtmf_pkg::AMP_W-1:0]           amplitude_i,
  output dtmf_pkg::dtmf_ctrl_t                 ctrl_o,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] sample_o
);
  import dtmf_pkg::*;

  logic signed [16:0] sin_sum;
  logic signed [15:0] amp_s;
  logic signed [32:0] prod_d;
  logic signed [32:0] prod_q;
  logic signed [32:0] biased;
  logic signed [32:0] scaled;
  dtmf_ctrl_t         ctrl_q;

  // sum and scale
  assign sin_sum = 17'(row_sin_i) + 17'(col_sin_i);
  assign amp_s   = $signed({1'b0, amplitude_i});
  assign prod_d  = $signed(33'(amp_s)) * $signed(33'(sin_sum));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  // round half up, floor shift, saturate; bad key gives silence
  assign biased = prod_q + 33'sd8192;
  assign scaled = biased >>> 14;

  always_comb begin
    if (ctrl_q.bad) begin
      sample_o = '0;
    end else if (scaled > 33'sd32767) begin
      sample_o = 16'sd32767;
    end else if (scaled < -33'sd32768) begin
      sample_o = -16'sd32768;
    end else begin
      sample_o = scaled[SAMPLE_W-1:0];
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

@@ hw/rtl/dtmf_tone_generator_top.sv @@
// ----------------------------------------------------------------------------
// dtmf_tone_generator_top
// DTMF dual-tone sample generator with stream in/out and a write-only
// configuration port.
//
// Usage:
//   Each transfer on the s_axis side is one sample tick carrying a key and a
//   start flag; each produces exactly one sample transfer on m_axis, in
//   order. tlast marks the last sample of a burst, tuser flags a bad key.
//   Samples pass the state stage, table lookup, mix register and output
//   queue. Throughput is one sample per cycle while s_axis_tready is high;
//   the phase/count state sits in a one-entry RAM, read at input transfer
//   and written back the next cycle, forwarding the value to the next item.
//   Results collect in an 8-entry output queue; s_axis_tready drops once 8
//   samples are in flight or waiting, so a stalled receiver holds the input
//   off without losing anything.
//   Reset clears the phases and counter (the state RAM reads as zero until
//   first written), loads amplitude 1.0 and a burst of 441000 samples, and
//   empties the queue. Write cfg_* only while no sample is in flight.
// ----------------------------------------------------------------------------
module dtmf_tone_generator_top #(
  parameter int SampleRate = dtmf_pkg::DEF_SAMPLE_RATE,
  parameter int PhaseBits  = dtmf_pkg::DEF_PHASE_BITS,
  parameter int SineDepth  = dtmf_pkg::DEF_SINE_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // digit[3:0], start_req[4]
  // output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [15:0]                          m_axis_tdata,  // sample[15:0]
  output logic                                 m_axis_tlast,  // tone_end
  output logic                                 m_axis_tuser,  // bad_digit
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [dtmf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dtmf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import dtmf_pkg::*;

  localparam int IdxW   = $clog2(SineDepth);
  localparam int QDepth = 8;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;
  localparam int QW     = SAMPLE_W + 2;

  logic                       in_xfer;
  logic                       out_xfer;
  logic [AMP_W-1:0]           amp_q;
  logic [COUNT_W-1:0]         tone_q;
  logic [IdxW-1:0]            row_idx;
  logic [IdxW-1:0]            col_idx;
  logic signed [15:0]         row_sin;
  logic signed [15:0]         col_sin;
  dtmf_ctrl_t                 rom_ctrl;
  dtmf_ctrl_t                 mix_ctrl;
  logic signed [SAMPLE_W-1:0] mix_sample;
  logic [QW-1:0]              queue_q [QDepth];
  logic [QPtrW-1:0]           wr_ptr_q;
  logic [QPtrW-1:0]           rd_ptr_q;
  logic [QCntW-1:0]           q_cnt_q;
  logic [QCntW-1:0]           inflight_q;
  logic [QW-1:0]              q_head;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= AMP_RESET;
      tone_q <= TONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMPLITUDE:    amp_q  <= cfg_data_i[AMP_W-1:0];
        CFG_TONE_SAMPLES: tone_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state read-modify-write and table index
  dtmf_phase #(
    .SampleRate (SampleRate),
    .PhaseBits  (PhaseBits),
    .SineDepth  (SineDepth)
  ) u_phase (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .digit_i        (s_axis_tdata[DIGIT_W-1:0]),
    .start_i        (s_axis_tdata[DIGIT_W]),
    .tone_samples_i (tone_q),
    .row_idx_o      (row_idx),
    .col_idx_o      (col_idx),
    .ctrl_o         (rom_ctrl)
  );

  // sine lookups, one per tone
  dtmf_sine_rom #(
    .Depth (SineDepth)
  ) u_row_rom (
    .clk_i  (clk_i),
    .addr_i (row_idx),
    .data_o (row_sin)
  );

  dtmf_sine_rom #(
    .Depth (SineDepth)
  ) u_col_rom (
    .clk_i  (clk_i),
    .addr_i (col_idx),
    .data_o (col_sin)
  );

  // mixing and output scaling
  dtmf_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rom_ctrl),
    .row_sin_i   (row_sin),
    .col_sin_i   (col_sin),
    .amplitude_i (amp_q),
    .ctrl_o      (mix_ctrl),
    .sample_o    (mix_sample)
  );

  // output queue storage
  always_ff @(posedge clk_i) begin
    if (mix_ctrl.valid) begin
      queue_q[wr_ptr_q] <= {mix_ctrl.bad, mix_ctrl.last, mix_sample};
    end
  end

  // queue pointers, fill count and in-flight credit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      q_cnt_q    <= '0;
      inflight_q <= '0;
    end else begin
      if (mix_ctrl.valid) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      q_cnt_q    <= q_cnt_q + QCntW'(mix_ctrl.valid) - QCntW'(out_xfer);
      inflight_q <= inflight_q + QCntW'(in_xfer) - QCntW'(out_xfer);
    end
  end

  assign s_axis_tready = inflight_q < QCntW'(QDepth);

  // output side
  assign q_head        = queue_q[rd_ptr_q];
  assign m_axis_tvalid = q_cnt_q != '0;
  assign m_axis_tdata  = q_head[SAMPLE_W-1:0];
  assign m_axis_tlast  = q_head[SAMPLE_W];
  assign m_axis_tuser  = q_head[SAMPLE_W+1];

`ifndef SYNTHESIS
  // credits never exceed queue room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= QCntW'(QDepth))
    else $error("in-flight count above queue depth");

  // queued samples are a subset of those in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= inflight_q)
    else $error("queue fill above in-flight count");

  // a finished sample never lands in a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_ctrl.valid |-> (q_cnt_q < QCntW'(QDepth)) || out_xfer)
    else $error("output queue overflow");

  // a bad key always comes out silent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("bad key sample not zero");
`endif

endmodule
